@@ hw/rtl/kmr_pkg.sv @@
`timescale 1ns / 1ps

package kmr_pkg;

   // Result fields carry the low 32 bits of each position.
   localparam int OUT_W = 32;

   // Configuration port.
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_DIST = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_DIST = 2'd1;
   localparam logic [CSR_DATA_W-1:0] MIN_DIST_RESET = 32'd100;
   localparam logic [CSR_DATA_W-1:0] MAX_DIST_RESET = 32'd20000;

   // Access strobes for the last-seen table.
   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } table_ctl_type;

endpackage

@@ hw/rtl/kmr_window.sv @@
`timescale 1ns / 1ps

module kmr_window #(
   parameter int KMER_LEN = 8,
   parameter int POS_BITS = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  logic [1:0]              base,
   input  logic                    is_break,
   output logic                    kmer_done,
   output logic [2*KMER_LEN-1:0]   kmer_idx,
   output logic [POS_BITS-1:0]     kmer_start
);

   localparam int CODE_BITS = 2 * KMER_LEN;
   localparam int RUN_W = $clog2(KMER_LEN + 1);
   localparam logic [RUN_W-1:0] RUN_FULL = RUN_W'(KMER_LEN);
   localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

   logic [CODE_BITS-1:0] window_ff, window_in;
   logic [RUN_W-1:0]     run_ff, run_in;
   logic [POS_BITS-1:0]  pos_ff, pos_in;
   logic [CODE_BITS-1:0] code_next;
   logic [RUN_W-1:0]     run_sat;

   always_comb begin
      code_next = CODE_BITS'({window_ff, base});
      run_sat = (run_ff == RUN_FULL) ? run_ff : run_ff + RUN_W'(1);
      kmer_done = !is_break && (run_sat == RUN_FULL);
      kmer_idx = code_next;
      kmer_start = pos_ff - POS_BITS'(KMER_LEN - 1);

      window_in = window_ff;
      run_in = run_ff;
      pos_in = pos_ff;
      if (accept) begin
         pos_in = (pos_ff != POS_MAX) ? pos_ff + POS_BITS'(1) : pos_ff;
         if (is_break) begin
            run_in = '0;
         end else begin
            window_in = code_next;
            run_in = run_sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
         run_ff <= '0;
         pos_ff <= '0;
      end else begin
         window_ff <= window_in;
         run_ff <= run_in;
         pos_ff <= pos_in;
      end
   end

endmodule

@@ hw/rtl/kmr_table.sv @@
`timescale 1ns / 1ps

module kmr_table #(
   parameter int ADDR_W = 16,
   parameter int DATA_W = 33
) (
   input  logic                   clock,
   input  logic                   reset,
   input  kmr_pkg::table_ctl_type ctl,
   input  logic [ADDR_W-1:0]      rd_addr,
   input  logic [ADDR_W-1:0]      wr_addr,
   input  logic [DATA_W-1:0]      wr_data,
   output logic [DATA_W-1:0]      rd_data,
   output logic                   clear_busy
);

   localparam logic [ADDR_W-1:0] ADDR_LAST = {ADDR_W{1'b1}};

   logic [DATA_W-1:0] mem_ff [2**ADDR_W];
   logic [DATA_W-1:0] rd_data_ff;
   logic              busy_ff, busy_in;
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;

   // The sweep writes a cleared entry (seen bit low) at every address after reset.
   always_comb begin
      busy_in = busy_ff;
      clr_addr_in = clr_addr_ff;
      if (busy_ff) begin
         clr_addr_in = clr_addr_ff + ADDR_W'(1);
         if (clr_addr_ff == ADDR_LAST) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (busy_ff) begin
         mem_ff[clr_addr_ff] <= '0;
      end else if (ctl.wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
   assign clear_busy = busy_ff;

endmodule

@@ hw/rtl/kmr_match.sv @@
`timescale 1ns / 1ps

module kmr_match #(
   parameter int POS_BITS = 32
) (
   input  logic [POS_BITS:0]              entry,
   input  logic                           fwd_hit,
   input  logic [POS_BITS-1:0]            fwd_pos,
   input  logic [POS_BITS-1:0]            start,
   input  logic [kmr_pkg::CSR_DATA_W-1:0] min_dist,
   input  logic [kmr_pkg::CSR_DATA_W-1:0] max_dist,
   output logic                           paired,
   output logic [kmr_pkg::OUT_W-1:0]      earlier_pos,
   output logic [kmr_pkg::OUT_W-1:0]      distance
);

   localparam int EXT_W = POS_BITS + kmr_pkg::OUT_W;

   logic                seen;
   logic [POS_BITS-1:0] prev;
   logic [POS_BITS-1:0] sep;
   logic [EXT_W-1:0]    dist_x, prev_x, min_x, max_x;

   always_comb begin
      // A write to the same entry in the cycle of the read wins over the stale data.
      seen = fwd_hit | entry[POS_BITS];
      prev = fwd_hit ? fwd_pos : entry[POS_BITS-1:0];
      sep = start - prev;
      dist_x = {kmr_pkg::OUT_W'(0), sep};
      prev_x = {kmr_pkg::OUT_W'(0), prev};
      min_x = {POS_BITS'(0), min_dist};
      max_x = {POS_BITS'(0), max_dist};
      paired = seen && (prev < start) && (dist_x >= min_x) && (dist_x <= max_x);
      earlier_pos = paired ? prev_x[kmr_pkg::OUT_W-1:0] : '0;
      distance = paired ? dist_x[kmr_pkg::OUT_W-1:0] : '0;
   end

endmodule

@@ hw/rtl/kmer_repeat_distance_pairer.sv @@
`timescale 1ns / 1ps

// Channel   Ports                                                               Direction
// req       req_valid req_ready req_base req_is_break                           in
// rsp       rsp_valid rsp_ready rsp_kmer_valid/_pos rsp_paired/_earlier_pos/_distance out
// csr       csr_valid csr_ready csr_index csr_data                              in
//
// One word per cycle is sustained unless rsp stalls.
// That figure is set by the last-seen table, which gets one read and one write each cycle.
// After reset all 4**KMER_LEN table entries (65536 by default) are swept clear while
// req_ready stays low; csr writes are taken at any time.
// A stall on rsp holds the output register and, through it, the lookup stage.

module kmer_repeat_distance_pairer #(
   parameter int KMER_LEN = 8,
   parameter int POS_BITS = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [1:0]                     req_base,
   input  logic                           req_is_break,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_kmer_valid,
   output logic [kmr_pkg::OUT_W-1:0]      rsp_kmer_pos,
   output logic                           rsp_paired,
   output logic [kmr_pkg::OUT_W-1:0]      rsp_earlier_pos,
   output logic [kmr_pkg::OUT_W-1:0]      rsp_distance,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [kmr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [kmr_pkg::CSR_DATA_W-1:0] csr_data
);

   localparam int CODE_BITS = 2 * KMER_LEN;
   localparam int EXT_W = POS_BITS + kmr_pkg::OUT_W;

   // Distance limits.
   logic [kmr_pkg::CSR_DATA_W-1:0] min_dist_ff, max_dist_ff;

   // Lookup stage: the word whose table entry is being read.
   logic                 s1_valid_ff, s1_valid_in;
   logic                 s1_kmer_ff;
   logic [CODE_BITS-1:0] s1_idx_ff;
   logic [POS_BITS-1:0]  s1_start_ff;
   logic                 fwd_hit_ff;
   logic [POS_BITS-1:0]  fwd_pos_ff;

   // Output register.
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_kmer_valid_ff;
   logic [kmr_pkg::OUT_W-1:0] rsp_kmer_pos_ff;
   logic                      rsp_paired_ff;
   logic [kmr_pkg::OUT_W-1:0] rsp_earlier_pos_ff;
   logic [kmr_pkg::OUT_W-1:0] rsp_distance_ff;

   logic                   accept;
   logic                   s1_adv;
   logic                   clear_busy;
   logic                   kmer_done;
   logic [CODE_BITS-1:0]   kmer_idx;
   logic [POS_BITS-1:0]    kmer_start;
   logic [POS_BITS:0]      rd_entry;
   kmr_pkg::table_ctl_type tbl_ctl;
   logic                   m_paired;
   logic [kmr_pkg::OUT_W-1:0] m_earlier_pos, m_distance;
   logic [EXT_W-1:0]       start_x;

   // The lookup stage moves on whenever the output register is free or being emptied,
   // so a new word can enter while the previous result still waits.
   assign s1_adv = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !clear_busy && (!s1_valid_ff || s1_adv);
   assign accept = req_valid && req_ready;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_dist_ff <= kmr_pkg::MIN_DIST_RESET;
         max_dist_ff <= kmr_pkg::MAX_DIST_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            kmr_pkg::CSR_MIN_DIST: min_dist_ff <= csr_data;
            kmr_pkg::CSR_MAX_DIST: max_dist_ff <= csr_data;
            default: ;
         endcase
      end
   end

   kmr_window #(
      .KMER_LEN (KMER_LEN),
      .POS_BITS (POS_BITS)
   ) u_window (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .base       (req_base),
      .is_break   (req_is_break),
      .kmer_done  (kmer_done),
      .kmer_idx   (kmer_idx),
      .kmer_start (kmer_start)
   );

   // Only completed k-mers touch the table; the lookup stage writes the new start
   // back as it hands its result to the output register.
   always_comb begin
      tbl_ctl.rd_en = accept && kmer_done;
      tbl_ctl.wr_en = s1_adv && s1_kmer_ff;
   end

   kmr_table #(
      .ADDR_W (CODE_BITS),
      .DATA_W (POS_BITS + 1)
   ) u_table (
      .clock      (clock),
      .reset      (reset),
      .ctl        (tbl_ctl),
      .rd_addr    (kmer_idx),
      .wr_addr    (s1_idx_ff),
      .wr_data    ({1'b1, s1_start_ff}),
      .rd_data    (rd_entry),
      .clear_busy (clear_busy)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   // A read issued in the same cycle as a write to the same entry sees the old
   // contents, so the written start is captured alongside and takes its place.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_kmer_ff <= kmer_done;
         s1_idx_ff <= kmer_idx;
         s1_start_ff <= kmer_start;
         fwd_hit_ff <= tbl_ctl.wr_en && (s1_idx_ff == kmer_idx);
         fwd_pos_ff <= s1_start_ff;
      end
   end

   kmr_match #(
      .POS_BITS (POS_BITS)
   ) u_match (
      .entry       (rd_entry),
      .fwd_hit     (fwd_hit_ff),
      .fwd_pos     (fwd_pos_ff),
      .start       (s1_start_ff),
      .min_dist    (min_dist_ff),
      .max_dist    (max_dist_ff),
      .paired      (m_paired),
      .earlier_pos (m_earlier_pos),
      .distance    (m_distance)
   );

   assign start_x = {kmr_pkg::OUT_W'(0), s1_start_ff};

   always_comb begin
      rsp_valid_in = s1_adv || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Words that complete no k-mer carry all-zero fields.
   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_kmer_valid_ff <= s1_kmer_ff;
         rsp_kmer_pos_ff <= s1_kmer_ff ? start_x[kmr_pkg::OUT_W-1:0] : '0;
         rsp_paired_ff <= s1_kmer_ff && m_paired;
         rsp_earlier_pos_ff <= s1_kmer_ff ? m_earlier_pos : '0;
         rsp_distance_ff <= s1_kmer_ff ? m_distance : '0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_kmer_valid = rsp_kmer_valid_ff;
   assign rsp_kmer_pos = rsp_kmer_pos_ff;
   assign rsp_paired = rsp_paired_ff;
   assign rsp_earlier_pos = rsp_earlier_pos_ff;
   assign rsp_distance = rsp_distance_ff;

`ifndef SYNTH
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      clear_busy |-> !req_ready)
      else $error("word accepted during table clear");

   a_accept_fills_stage: assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_valid_ff)
      else $error("accepted word missing from lookup stage");

   a_pair_needs_kmer: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_paired_ff |-> rsp_kmer_valid_ff)
      else $error("pair reported without a k-mer");

   a_pair_in_limits: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_paired_ff |->
         rsp_distance_ff >= min_dist_ff && rsp_distance_ff <= max_dist_ff)
      else $error("pair distance outside limits");

   a_stall_holds_stage: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_adv |=> s1_valid_ff && $stable(s1_start_ff))
      else $error("stalled lookup stage changed");
`endif

endmodule
